@@ hw/rtl/sha_pkg.sv @@
// Shared types, constants and a rotate helper of the SHA-256 stream engine.
package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_data;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_word_t;

  // One finished 512-bit block passed from the front to the core.
  typedef struct packed {
    logic [511:0] block;
    logic         final_blk;
  } blk_t;

  // The queue depth is a power of two so the pointers wrap on their own.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned n);
    ror = (v >> n) | (v << (32 - n));
  endfunction

endpackage

@@ hw/rtl/sha_front.sv @@
// Front end: collects bytes into blocks, appends padding and length.
module sha_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  sha_pkg::in_word_t in_data,
  output logic              blk_valid,
  input  logic              blk_ready,
  output sha_pkg::blk_t     blk_data
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    ST_TAKE = 3'b001,
    ST_PAD  = 3'b010,
    ST_SEND = 3'b100
  } fstate_t;

  fstate_t      state_r, state_nxt;
  logic [511:0] buf_r, buf_nxt;
  logic [6:0]   fill_r, fill_nxt;
  logic [63:0]  bits_r, bits_nxt;
  logic         fin_r, fin_nxt;      // message end seen, padding pending
  logic         lenin_r, lenin_nxt;  // the length is in the held block
  logic         padb_r, padb_nxt;    // the 0x80 byte has been placed

  // A full block leaves in ST_SEND; padding proceeds one byte per cycle.
  assign in_full   = (state_r != ST_TAKE);
  assign blk_valid = (state_r == ST_SEND);
  assign blk_data  = '{block: buf_r, final_blk: lenin_r};

  always_comb begin
    logic [7:0] pb;
    state_nxt = state_r;
    buf_nxt   = buf_r;
    fill_nxt  = fill_r;
    bits_nxt  = bits_r;
    fin_nxt   = fin_r;
    lenin_nxt = lenin_r;
    padb_nxt  = padb_r;
    pb        = 8'h00;
    case (state_r)
      ST_TAKE: begin
        if (in_push) begin
          if (in_data.has_data) begin
            buf_nxt[511 - 8*fill_r[5:0] -: 8] = in_data.data_byte;
            fill_nxt = fill_r + 7'd1;
            bits_nxt = bits_r + 64'd8;
          end
          if (in_data.last_byte) begin
            fin_nxt   = 1'b1;
            padb_nxt  = 1'b0;
            state_nxt = ST_PAD;
          end
          if (in_data.has_data && fill_r == 7'd63) state_nxt = ST_SEND;
        end
      end
      ST_PAD: begin
        // The length goes in only once the 0x80 byte is in place.
        if (fill_r == 7'd56 && padb_r) begin
          buf_nxt[63:0] = bits_r;
          lenin_nxt = 1'b1;
          fill_nxt  = 7'd64;
          state_nxt = ST_SEND;
        end else begin
          pb = padb_r ? 8'h00 : PadByte;
          buf_nxt[511 - 8*fill_r[5:0] -: 8] = pb;
          padb_nxt = 1'b1;
          fill_nxt = fill_r + 7'd1;
          if (fill_r == 7'd63) state_nxt = ST_SEND;
        end
      end
      ST_SEND: begin
        if (blk_ready) begin
          fill_nxt = 7'd0;
          if (lenin_r) begin
            lenin_nxt = 1'b0;
            fin_nxt   = 1'b0;
            bits_nxt  = 64'd0;
            state_nxt = ST_TAKE;
          end else if (fin_r) begin
            state_nxt = ST_PAD;
          end else begin
            state_nxt = ST_TAKE;
          end
        end
      end
      default: state_nxt = ST_TAKE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_TAKE;
      fill_r  <= 7'd0;
      bits_r  <= 64'd0;
      fin_r   <= 1'b0;
      lenin_r <= 1'b0;
      padb_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      bits_r  <= bits_nxt;
      fin_r   <= fin_nxt;
      lenin_r <= lenin_nxt;
      padb_r  <= padb_nxt;
    end
    buf_r <= buf_nxt;
  end

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 7'd64) else $error("block fill out of range");
  a_len_final: assert property (@(posedge clk) disable iff (!rst_n)
    lenin_r |-> (state_r == ST_SEND)) else $error("length block not held");
  a_send_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEND) |-> (fill_r == 7'd64)) else $error("partial block sent");
`endif
endmodule

@@ hw/rtl/sha_queue.sv @@
// Short block queue between the front end and the compression core.
module sha_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  sha_pkg::blk_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output sha_pkg::blk_t rd_data
);
  import sha_pkg::*;

  blk_t                 mem_r [QueueDepth];
  logic [QueuePtrW-1:0] wp_r, rp_r;
  logic [QueueCntW-1:0] cnt_r;
  logic                 wr_en, rd_en;

  assign wr_ready = (cnt_r != QueueCntW'(QueueDepth));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + QueueCntW'(wr_en) - QueueCntW'(rd_en);
    end
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

`ifndef SYNTHESIS
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QueueCntW'(QueueDepth)) else $error("queue count overflow");
  a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r - rp_r) == cnt_r[QueuePtrW-1:0]) else $error("queue pointers disagree with count");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_valid && !rd_ready) |=> rd_valid) else $error("queue lost a block");
`endif
endmodule

@@ hw/rtl/sha_core.sv @@
// Compression core: one round per cycle, then digest emission after a final block.
module sha_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                blk_valid,
  output logic                blk_ready,
  input  sha_pkg::blk_t       blk_data,
  output logic                out_empty,
  input  logic                out_pop,
  output sha_pkg::out_word_t  out_data
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_EMIT = 3'b100
  } cstate_t;

  cstate_t     state_r;
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [5:0]  rnd_r;
  logic        fin_r;
  logic [2:0]  idx_r;
  logic [31:0] wt, s1, s2;

  assign blk_ready = (state_r == ST_IDLE);
  assign out_empty = (state_r != ST_EMIT);
  assign out_data  = '{digest_word: h_r[idx_r], word_index: idx_r,
                       last_word: (idx_r == 3'd7)};

  always_comb begin
    logic [31:0] m2, m15;
    m2  = w_r[14];
    m15 = w_r[1];
    if (rnd_r < 6'd16) wt = w_r[0];
    else wt = (ror(m2, 17) ^ ror(m2, 19) ^ (m2 >> 10)) + w_r[9] +
              (ror(m15, 7) ^ ror(m15, 18) ^ (m15 >> 3)) + w_r[0];
    s1 = v_r[7] + (ror(v_r[4], 6) ^ ror(v_r[4], 11) ^ ror(v_r[4], 25)) +
         ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + RoundK[rnd_r] + wt;
    s2 = (ror(v_r[0], 2) ^ ror(v_r[0], 13) ^ ror(v_r[0], 22)) +
         ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  // The window shifts each round: w_r[0] is the current word, w_r[15] newest.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      rnd_r   <= 6'd0;
      idx_r   <= 3'd0;
      fin_r   <= 1'b0;
      for (int k = 0; k < 8; k++) h_r[k] <= InitHash[k];
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (blk_valid) begin
            for (int k = 0; k < 16; k++) w_r[k] <= blk_data.block[511 - 32*k -: 32];
            for (int k = 0; k < 8; k++) v_r[k] <= h_r[k];
            fin_r   <= blk_data.final_blk;
            rnd_r   <= 6'd0;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          for (int k = 0; k < 15; k++) w_r[k] <= w_r[k+1];
          w_r[15] <= wt;
          v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + s1;
          v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
          v_r[0] <= s1 + s2;
          rnd_r  <= rnd_r + 6'd1;
          if (rnd_r == 6'd63) begin
            for (int k = 1; k < 8; k++) begin
              if (k != 4) h_r[k] <= h_r[k] + v_r[k-1];
            end
            h_r[0]  <= h_r[0] + s1 + s2;
            h_r[4]  <= h_r[4] + v_r[3] + s1;
            idx_r   <= 3'd0;
            state_r <= fin_r ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_pop) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              for (int k = 0; k < 8; k++) h_r[k] <= InitHash[k];
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_emit_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_EMIT) |-> (idx_r == 3'd0)) else $error("digest not from h0");
  a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && rnd_r != 6'd63) |=> (state_r == ST_RUN))
    else $error("compression left early");
  a_reinit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_pop && idx_r == 3'd7) |=> (h_r[0] == InitHash[0]))
    else $error("hash not reinitialized");
`endif
endmodule

@@ hw/rtl/sha256_stream_hash.sv @@
// Top level of the streaming SHA-256 engine.
// Flow: the front packs bytes into blocks; after a last word it pads one byte per cycle,
// and the core compresses one block at a time.
// Throughput: one byte per cycle while the front is taking bytes and the block queue
// has room; the sustained block rate is set by both the front and the round unit.
// Reset (rst_n low, synchronous) clears all control and restores initial hashes.
module sha256_stream_hash (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  sha_pkg::in_word_t   in_data,
  output logic                out_empty,
  input  logic                out_pop,
  output sha_pkg::out_word_t  out_data
);
  import sha_pkg::*;

  // The front end packs bytes and padding into blocks; the queue decouples
  // it from the core so bytes keep flowing while a block is compressed.
  logic  f_valid, f_ready, q_valid, q_ready;
  blk_t  f_blk, q_blk;

  sha_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_data,
    .blk_valid(f_valid), .blk_ready(f_ready), .blk_data(f_blk)
  );

  sha_queue u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_blk),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_blk)
  );

  // The core holds each digest word on the output until it is popped.
  sha_core u_core (
    .clk, .rst_n,
    .blk_valid(q_valid), .blk_ready(q_ready), .blk_data(q_blk),
    .out_empty, .out_pop, .out_data
  );
endmodule

@@ sim/sha256_digest_checker.sv @@
// Checker for the SHA-256 stream engine: predicts digest words and compares them.
`timescale 1ns / 100ps
module sha256_digest_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  logic               in_full,
  input  sha_pkg::in_word_t  in_data,
  input  logic               out_empty,
  input  logic               out_pop,
  input  sha_pkg::out_word_t out_data,
  output int                 fail_count,
  output int                 pending_words,
  output int                 digest_count
);
  import sha_pkg::*;

  localparam logic [31:0] StartHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam logic [31:0] RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  logic [31:0] chain [8];
  logic [7:0]  block_bytes [64];
  int unsigned fill;
  logic [63:0] bit_len;
  out_word_t   digest_q [$];

  function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7] +
             (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                chain[4], chain[5], chain[6], chain[7]};
    for (int t = 0; t < 64; t++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) +
           RoundConst[t] + w[t];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endtask

  task automatic append_byte(input logic [7:0] v);
    block_bytes[fill] = v;
    fill++;
    if (fill == 64) begin
      compress();
      fill = 0;
    end
  endtask

  task automatic absorb_word(input in_word_t iw);
    logic [63:0] len;
    out_word_t   ow;
    if (iw.has_data) begin
      append_byte(iw.data_byte);
      bit_len += 64'd8;
    end
    if (iw.last_byte) begin
      len = bit_len;
      append_byte(PadByte);
      while (fill != 56) append_byte(8'h00);
      for (int k = 0; k < 8; k++) append_byte(len[63-8*k -: 8]);
      for (int k = 0; k < 8; k++) begin
        ow.digest_word = chain[k];
        ow.word_index  = 3'(k);
        ow.last_word   = (k == 7);
        digest_q = {digest_q, ow};
      end
      chain   = StartHash;
      fill    = 0;
      bit_len = '0;
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch: %s got %h expected %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    digest_count = 0;
    chain = StartHash;
    fill = 0;
    bit_len = '0;
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (digest_q.size() == 0) begin
          report("unexpected digest word", out_data.digest_word, 32'h0);
        end else begin
          want = digest_q.pop_front();
          if (out_data.digest_word !== want.digest_word)
            report("digest_word", out_data.digest_word, want.digest_word);
          if (out_data.word_index !== want.word_index)
            report("word_index", 32'(out_data.word_index), 32'(want.word_index));
          if (out_data.last_word !== want.last_word)
            report("last_word", 32'(out_data.last_word), 32'(want.last_word));
          if (want.last_word) digest_count++;
        end
      end
      if (in_push && !in_full) absorb_word(in_data);
    end
    pending_words <= digest_q.size();
  end
endmodule

@@ sim/sha256_stream_hash_tb.sv @@
// Testbench top: drives bytes into the SHA-256 stream engine and gives the verdict.
`timescale 1ns / 100ps
module sha256_stream_hash_tb;
  import sha_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_push;
  logic      in_full;
  in_word_t  in_data;
  logic      out_empty;
  logic      out_pop;
  out_word_t out_data;
  int        fail_count;
  int        pending_words;
  int        digest_count;
  int        cycle_count;
  int        words_sent;
  bit        steady;      // when set, neither side idles

  sha256_stream_hash dut (
    .clk, .rst_n, .in_push, .in_full, .in_data, .out_empty, .out_pop, .out_data
  );

  sha256_digest_checker u_checker (
    .clk, .rst_n, .in_push, .in_full, .in_data, .out_empty, .out_pop, .out_data,
    .fail_count, .pending_words, .digest_count
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a run that outlasts the limit below is ended as a failure; the
  // limit is set to hold even if every word ends a message.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 1000000) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // The receiver pops at random, except during the steady stretch.
  always @(posedge clk) begin
    if (!rst_n) out_pop <= 1'b0;
    else out_pop <= steady || ($urandom_range(99) >= 37);
  end

  // Offer one word and hold it until the engine accepts it. The sender may
  // idle first, so gaps land on every phase of the block work.
  task automatic send_word(input logic [7:0] b, input logic has, input logic fin);
    while (!steady && $urandom_range(99) < 37) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= '{data_byte: b, has_data: has, last_byte: fin};
    @(posedge clk);
    while (in_full) @(posedge clk);
    words_sent++;
  endtask

  // A message of random bytes; the final byte carries the end mark, or an
  // empty final word follows it.
  task automatic send_message(input int len, input bit empty_tail);
    for (int i = 0; i < len; i++)
      send_word(8'($urandom), 1'b1, !empty_tail && i == len - 1);
    if (empty_tail || len == 0) send_word(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int len;
    rst_n       = 1'b0;
    in_push     = 1'b0;
    in_data     = '0;
    steady      = 1'b0;
    words_sent  = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: the empty message, a single byte at each extreme, a word with
    // neither data nor end mark (which must change nothing), and the
    // padding boundaries at 55, 56 and 64 bytes.
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'h00, 1'b1, 1'b1);
    send_word(8'hff, 1'b1, 1'b1);
    send_word(8'h61, 1'b1, 1'b0);
    send_word(8'hff, 1'b0, 1'b0);
    send_word(8'h62, 1'b1, 1'b0);
    send_word(8'h63, 1'b1, 1'b0);
    send_word(8'h00, 1'b0, 1'b1);
    send_word(8'haa, 1'b1, 1'b0);
    send_word(8'h55, 1'b1, 1'b1);
    send_message(55, 1'b0);
    send_message(56, 1'b0);
    send_message(64, 1'b1);

    // Random part: mostly short messages, a few spanning several blocks,
    // with the odd no-op word mixed in. A stretch in the middle runs with
    // no idling on either side.
    while (words_sent < 460) begin
      steady = (words_sent > 250 && words_sent < 350);
      if ($urandom_range(9) == 0) send_word(8'($urandom), 1'b0, 1'b0);
      len = ($urandom_range(9) == 0) ? $urandom_range(130, 64) : $urandom_range(20);
      send_message(len, $urandom_range(3) == 0);
    end
    steady = 1'b0;
    in_push <= 1'b0;

    // Let the checker count the last message before waiting on it.
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("%0d words sent, %0d digests checked", words_sent, digest_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
